[rtl/core/crdg_pkg.sv]
package crdg_pkg;

  localparam int UV_FRAC_BITS = 16;
  localparam int PIX_W        = 16;
  localparam int VEC_W        = 48;
  localparam int LANE_W       = 16;
  localparam int NORM_MSB     = 29;
  localparam int NORM_W       = NORM_MSB + 1;
  localparam int DIVA_STAGES  = PIX_W + UV_FRAC_BITS + 1;
  localparam int ROOT_STAGES  = 32;
  localparam int ROOT_W       = 63;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  typedef enum logic [2:0] {
    REG_VIEW_NORMAL = 3'd0,
    REG_SIDE_STEP   = 3'd1,
    REG_UP_STEP     = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4
  } reg_idx_t;

endpackage

[rtl/core/camera_ray_direction_gen_top.sv]
// Each point passes through the u and v dividers, the product, sum and normalize registers,
// the square root, the normalizing divide and the output register.
// Throughput: one point per cycle while the pipeline is not held, through bit-per-stage
// dividers for u, v and the normalize step, and a bit-pair-per-stage square root.
// Hold the whole pipeline while the output register is full and not taken.
// Reset (rst, synchronous) clears all valid bits, zeroes the vectors, sets centers to 16.
module camera_ray_direction_gen_top
  import crdg_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // pixel_x, pixel_y
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // dir_x, dir_y, dir_z
  output logic              m_tuser    // zero_length
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NW = NORM_W + OUT_FRAC_BITS + 1;
  localparam int DA = DIVA_STAGES;
  localparam int SQ = ROOT_STAGES;

  logic [VEC_W-1:0] view_normal, side_step, up_step;
  logic [PIX_W-1:0] center_x, center_y;
  reg_idx_t         widx;
  logic             adv;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      view_normal <= '0;
      side_step   <= '0;
      up_step     <= '0;
      center_x    <= 16'd16;
      center_y    <= 16'd16;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_VIEW_NORMAL: view_normal <= pwdata[VEC_W-1:0];
        REG_SIDE_STEP:   side_step   <= pwdata[VEC_W-1:0];
        REG_UP_STEP:     up_step     <= pwdata[VEC_W-1:0];
        REG_CENTER_X:    center_x    <= pwdata[PIX_W-1:0];
        REG_CENTER_Y:    center_y    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_VIEW_NORMAL: prdata = DATA_W'(view_normal);
      REG_SIDE_STEP:   prdata = DATA_W'(side_step);
      REG_UP_STEP:     prdata = DATA_W'(up_step);
      REG_CENTER_X:    prdata = DATA_W'(center_x);
      REG_CENTER_Y:    prdata = DATA_W'(center_y);
      default:         prdata = '0;
    endcase
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // u and v dividers: lane 0 is x, lane 1 is y
  logic             da_v   [DA+1];
  logic [DA-1:0]    da_num [DA+1][2];
  logic [PIX_W-1:0] da_d   [DA+1][2];
  logic [PIX_W-1:0] da_rem [DA+1][2];
  logic [DA-1:0]    da_q   [DA+1][2];
  logic             da_neg [DA+1][2];

  logic [PIX_W-1:0] in_p [2];
  logic [PIX_W-1:0] in_c [2];

  assign in_p[0] = s_tdata[15:0];
  assign in_p[1] = s_tdata[31:16];
  assign in_c[0] = center_x;
  assign in_c[1] = center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      da_v[0] <= 1'b0;
    end else if (adv) begin
      da_v[0] <= s_tvalid;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_in
    logic [PIX_W-1:0] d, off;
    logic             ng;
    always_comb begin
      d   = (in_c[l] == '0) ? PIX_W'(1) : in_c[l];
      ng  = in_p[l] < in_c[l];
      off = ng ? in_c[l] - in_p[l] : in_p[l] - in_c[l];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        da_num[0][l] <= {1'b0, off, {UV_FRAC_BITS{1'b0}}} + DA'(d >> 1);
        da_d[0][l]   <= d;
        da_rem[0][l] <= '0;
        da_q[0][l]   <= '0;
        da_neg[0][l] <= ng;
      end
    end
  end

  for (genvar k = 0; k < DA; k++) begin : g_diva
    always_ff @(posedge clk) begin
      if (rst) begin
        da_v[k+1] <= 1'b0;
      end else if (adv) begin
        da_v[k+1] <= da_v[k];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [PIX_W:0] trial;
      logic           ge;
      always_comb begin
        trial = {da_rem[k][l], da_num[k][l][DA-1-k]};
        ge    = trial >= {1'b0, da_d[k][l]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          da_num[k+1][l] <= da_num[k][l];
          da_d[k+1][l]   <= da_d[k][l];
          da_neg[k+1][l] <= da_neg[k][l];
          da_rem[k+1][l] <= ge ? PIX_W'(trial - {1'b0, da_d[k][l]}) : trial[PIX_W-1:0];
          da_q[k+1][l]   <= {da_q[k][l][DA-2:0], ge};
        end
      end
    end
  end

  // products
  logic signed [DA:0]   u_s, v_s;
  logic                 pm_v;
  logic signed [DA+16:0] pm_s [3];
  logic signed [DA+16:0] pm_u [3];
  logic signed [LANE_W-1:0] pm_n [3];

  assign u_s = da_neg[DA][0] ? -$signed({1'b0, da_q[DA][0]}) : $signed({1'b0, da_q[DA][0]});
  assign v_s = da_neg[DA][1] ? $signed({1'b0, da_q[DA][1]}) : -$signed({1'b0, da_q[DA][1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      pm_v <= 1'b0;
    end else if (adv) begin
      pm_v <= da_v[DA];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (adv) begin
        pm_s[k] <= $signed(side_step[16*k +: 16]) * u_s;
        pm_u[k] <= $signed(up_step[16*k +: 16]) * v_s;
        pm_n[k] <= $signed(view_normal[16*k +: 16]);
      end
    end
  end

  // sum, magnitude, maximum, normalizing shift, squares and their sum
  localparam int CW = DA + 19;
  logic                 sc_v, mg_v, mx_v, lz_v, sh_v, sq_v, ss_v;
  logic signed [CW-1:0] sc [3];
  logic [CW-2:0]        mg [3], mxm [3], lzm [3];
  logic                 mg_neg [3], mx_neg [3], lz_neg [3], sh_neg [3], sq_neg [3], ss_neg [3];
  logic [CW-2:0]        mx;
  logic [5:0]           lz_pos;
  logic                 lz_zero, sh_zero, sq_zero, ss_zero;
  logic [NORM_W-1:0]    sh [3], sq_m [3], ss_m [3];
  logic [2*NORM_W-1:0]  sq [3];
  logic [ROOT_W-1:0]    ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
      mg_v <= 1'b0;
      mx_v <= 1'b0;
      lz_v <= 1'b0;
      sh_v <= 1'b0;
      sq_v <= 1'b0;
      ss_v <= 1'b0;
    end else if (adv) begin
      sc_v <= pm_v;
      mg_v <= sc_v;
      mx_v <= mg_v;
      lz_v <= mx_v;
      sh_v <= lz_v;
      sq_v <= sh_v;
      ss_v <= sq_v;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mag
    logic [CW-2:0] shl, shr;
    assign shl = lzm[k] << (NORM_MSB - lz_pos);
    assign shr = lzm[k] >> (lz_pos - NORM_MSB);
    always_ff @(posedge clk) begin
      if (adv) begin
        sc[k]     <= (CW'(pm_n[k]) <<< UV_FRAC_BITS) + CW'(pm_s[k]) + CW'(pm_u[k]);
        mg_neg[k] <= sc[k][CW-1];
        mg[k]     <= sc[k][CW-1] ? (CW-1)'(-sc[k]) : sc[k][CW-2:0];
        mxm[k]    <= mg[k];
        mx_neg[k] <= mg_neg[k];
        lzm[k]    <= mxm[k];
        lz_neg[k] <= mx_neg[k];
        sh[k]     <= (lz_pos >= 6'(NORM_MSB)) ? shr[NORM_W-1:0] : shl[NORM_W-1:0];
        sh_neg[k] <= lz_neg[k];
        sq[k]     <= sh[k] * sh[k];
        sq_m[k]   <= sh[k];
        sq_neg[k] <= sh_neg[k];
        ss_m[k]   <= sq_m[k];
        ss_neg[k] <= sq_neg[k];
      end
    end
  end

  logic [CW-2:0] m01;
  logic [5:0]    pos_c;
  assign m01 = (mg[0] > mg[1]) ? mg[0] : mg[1];

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < CW - 1; i++) begin
      if (mx[i]) begin
        pos_c = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx      <= (m01 > mg[2]) ? m01 : mg[2];
      lz_pos  <= pos_c;
      lz_zero <= mx == '0;
      sh_zero <= lz_zero;
      sq_zero <= sh_zero;
      ss_zero <= sq_zero;
      ss      <= ROOT_W'(sq[0]) + ROOT_W'(sq[1]) + ROOT_W'(sq[2]);
    end
  end

  // square root, two radicand bits a stage
  logic              rt_v    [SQ+1];
  logic [ROOT_W-1:0] rt_n    [SQ+1];
  logic [ROOT_W-1:0] rt_r    [SQ+1];
  logic [NORM_W-1:0] rt_m    [SQ+1][3];
  logic              rt_neg  [SQ+1][3];
  logic              rt_zero [SQ+1];

  assign rt_v[0]    = ss_v;
  assign rt_n[0]    = ss;
  assign rt_r[0]    = '0;
  assign rt_zero[0] = ss_zero;
  for (genvar k = 0; k < 3; k++) begin : g_rt0
    assign rt_m[0][k]   = ss_m[k];
    assign rt_neg[0][k] = ss_neg[k];
  end

  for (genvar i = 0; i < SQ; i++) begin : g_root
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 1 - 2 * i);
    logic [ROOT_W-1:0] t;
    logic              ge;
    assign t  = rt_r[i] + BIT;
    assign ge = rt_n[i] >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[i+1] <= 1'b0;
      end else if (adv) begin
        rt_v[i+1] <= rt_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_n[i+1]    <= ge ? rt_n[i] - t : rt_n[i];
        rt_r[i+1]    <= ge ? (rt_r[i] >> 1) + BIT : rt_r[i] >> 1;
        rt_zero[i+1] <= rt_zero[i];
        rt_m[i+1]    <= rt_m[i];
        rt_neg[i+1]  <= rt_neg[i];
      end
    end
  end

  // normalizing divide
  localparam int LW = NORM_W + 1;
  logic [LW-1:0]  len;
  logic           db_v    [QW+1];
  logic [LW-1:0]  db_len  [QW+1];
  logic [LW-1:0]  db_rem  [QW+1][3];
  logic [QW-1:0]  db_num  [QW+1][3];
  logic [QW-1:0]  db_q    [QW+1][3];
  logic           db_neg  [QW+1][3];
  logic           db_zero [QW+1];

  assign len = rt_r[SQ][LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      db_v[0] <= 1'b0;
    end else if (adv) begin
      db_v[0] <= rt_v[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      db_len[0]  <= len;
      db_zero[0] <= rt_zero[SQ];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_db0
    logic [NW-1:0] n;
    assign n = {1'b0, rt_m[SQ][k], {OUT_FRAC_BITS{1'b0}}} + NW'(len >> 1);
    always_ff @(posedge clk) begin
      if (adv) begin
        db_rem[0][k] <= LW'(n[NW-1:QW]);
        db_num[0][k] <= n[QW-1:0];
        db_q[0][k]   <= '0;
        db_neg[0][k] <= rt_neg[SQ][k];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_divb
    always_ff @(posedge clk) begin
      if (rst) begin
        db_v[j+1] <= 1'b0;
      end else if (adv) begin
        db_v[j+1] <= db_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        db_len[j+1]  <= db_len[j];
        db_zero[j+1] <= db_zero[j];
      end
    end
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [LW:0] trial;
      logic        ge;
      assign trial = {db_rem[j][k], db_num[j][k][QW-1-j]};
      assign ge    = trial >= {1'b0, db_len[j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          db_rem[j+1][k] <= ge ? LW'(trial - {1'b0, db_len[j]}) : trial[LW-1:0];
          db_num[j+1][k] <= db_num[j][k];
          db_q[j+1][k]   <= {db_q[j][k][QW-2:0], ge};
          db_neg[j+1][k] <= db_neg[j][k];
        end
      end
    end
  end

  // saturate and output register
  logic [15:0] dir [3];

  for (genvar k = 0; k < 3; k++) begin : g_sat
    logic [31:0] q32;
    logic [16:0] qn;
    assign q32 = 32'(db_q[QW][k]);
    assign qn  = (q32 > 32'd32768) ? 17'h08000 : q32[16:0];
    always_comb begin
      if (db_zero[QW]) begin
        dir[k] = '0;
      end else if (db_neg[QW][k]) begin
        dir[k] = 16'(~qn + 17'd1);
      end else begin
        dir[k] = (q32 > 32'd32767) ? 16'h7fff : q32[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= db_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {dir[2], dir[1], dir[0]};
      m_tuser <= db_zero[QW];
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero_length result carries a nonzero direction");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    sh_v && !sh_zero |-> (sh[0][NORM_MSB] || sh[1][NORM_MSB] || sh[2][NORM_MSB]))
    else $error("normalized maximum outside its range");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    rt_v[SQ] && !rt_zero[SQ] |-> len[LW-1:NORM_MSB] != '0)
    else $error("vector length below normalized maximum");

endmodule

[tb/camera_ray_direction_gen_checker.sv]
`timescale 1ns / 100ps
module camera_ray_direction_gen_checker
  import crdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    logic        zl;
  } ray_dir_t;

  logic [47:0] view_normal, side_step, up_step;
  logic [15:0] center_x, center_y;
  ray_dir_t    ray_queue[$];

  function automatic longint signed pixel_ratio(longint unsigned p, longint unsigned c);
    longint unsigned d, off, q;
    d = (c == 0) ? 1 : c;
    off = (p < c) ? c - p : p - c;
    q = ((off << UV_FRAC_BITS) + d / 2) / d;
    return (p < c) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_dir_t predict_ray(logic [15:0] px, logic [15:0] py);
    longint signed   u, v, c;
    longint unsigned mag[3], mx, sq, len, q;
    logic            neg[3];
    logic [15:0]     r[3];
    ray_dir_t        res;
    u = pixel_ratio(px, center_x);
    v = -pixel_ratio(py, center_y);
    mx = 0;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      c = longint'($signed(view_normal[16*k +: 16])) * (64'sd1 << UV_FRAC_BITS)
        + longint'($signed(side_step[16*k +: 16])) * u
        + longint'($signed(up_step[16*k +: 16])) * v;
      neg[k] = c < 0;
      mag[k] = neg[k] ? longint'(-c) : longint'(c);
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      res = '{16'd0, 16'd0, 16'd0, 1'b1};
      return res;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 14) + len / 2) / len;
      if (neg[k]) begin
        if (q > 32768) q = 32768;
        r[k] = 16'(-q);
      end else begin
        if (q > 32767) q = 32767;
        r[k] = 16'(q);
      end
    end
    res = '{r[0], r[1], r[2], 1'b0};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = ray_queue.size();

  always @(posedge clk) begin
    ray_dir_t want;
    if (rst) begin
      view_normal <= '0;
      side_step   <= '0;
      up_step     <= '0;
      center_x    <= 16'd16;
      center_y    <= 16'd16;
      fail_count  = 0;
      ray_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr >> 3))
          REG_VIEW_NORMAL: view_normal <= pwdata[47:0];
          REG_SIDE_STEP:   side_step   <= pwdata[47:0];
          REG_UP_STEP:     up_step     <= pwdata[47:0];
          REG_CENTER_X:    center_x    <= pwdata[15:0];
          REG_CENTER_Y:    center_y    <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) ray_queue.push_back(predict_ray(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        if (ray_queue.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata[15:0], 16'd0);
        end else begin
          want = ray_queue.pop_front();
          if (m_tdata[15:0] !== want.dx) report_mismatch("dir_x", m_tdata[15:0], want.dx);
          if (m_tdata[31:16] !== want.dy) report_mismatch("dir_y", m_tdata[31:16], want.dy);
          if (m_tdata[47:32] !== want.dz) report_mismatch("dir_z", m_tdata[47:32], want.dz);
          if (m_tuser !== want.zl) report_mismatch("zero_length", 16'(m_tuser), 16'(want.zl));
        end
      end
    end
  end

endmodule

[tb/tb_camera_ray_direction_gen_top.sv]
`timescale 1ns / 100ps
module tb_camera_ray_direction_gen_top;
  import crdg_pkg::*;

  localparam int LATENCY   = 90;
  localparam int WDOG_MAX  = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;  // pixel_x, pixel_y
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;       // dir_x, dir_y, dir_z
  logic              m_tuser;       // zero_length
  int                fail_count, pending, idle_cycles;
  bit                calm;

  always #6 clk = ~clk;

  camera_ray_direction_gen_top i_dut (.*);

  camera_ray_direction_gen_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("tb_camera_ray_direction_gen_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 3;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_pixel(logic [15:0] px, logic [15:0] py);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand_vec(int spread);
    logic [47:0] v;
    for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(2 * spread) - spread);
    return v;
  endfunction

  task automatic configure(logic [47:0] vn, logic [47:0] ss, logic [47:0] us,
                           logic [15:0] cx, logic [15:0] cy);
    write_reg(REG_VIEW_NORMAL, {16'd0, vn});
    write_reg(REG_SIDE_STEP, {16'd0, ss});
    write_reg(REG_UP_STEP, {16'd0, us});
    write_reg(REG_CENTER_X, {48'd0, cx});
    write_reg(REG_CENTER_Y, {48'd0, cy});
  endtask

  initial begin
    logic [15:0] cx, cy;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(16'd16, 16'd16);
    send_pixel(16'd0, 16'd0);
    end_burst();
    drain();

    configure({16'h0000, 16'h0000, 16'h1000}, {16'h0000, 16'h1000, 16'h0000},
              {16'h1000, 16'h0000, 16'h0000}, 16'd5120, 16'd3840);
    send_pixel(16'd5120, 16'd3840);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h5555);
    end_burst();
    drain();

    configure({16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF},
              {16'h8000, 16'h8000, 16'hFFFF}, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'd1, 16'd1);
    end_burst();
    drain();

    configure(48'h0, {16'h0, 16'h0, 16'h1000}, 48'h0, 16'd16, 16'd16);
    send_pixel(16'd16, 16'd99);
    send_pixel(16'd17, 16'd0);
    send_pixel(16'd15, 16'd0);
    end_burst();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      cx = (ph == 0) ? 16'd16 : (ph == 1) ? 16'hFFFF : 16'($urandom_range(16, 8000));
      cy = (ph == 2) ? 16'd16 : (ph == 1) ? 16'hFFFF : 16'($urandom_range(16, 8000));
      configure(rand_vec(ph == 3 ? 32767 : 4096), rand_vec(ph == 4 ? 32767 : 4096),
                rand_vec(4096), cx, cy);
      calm = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) == 0) begin
          send_pixel(16'($urandom), 16'($urandom));
        end else begin
          send_pixel(16'($urandom_range(0, 2 * cx > 16'hFFFF ? 16'hFFFF : 2 * cx)),
                     16'($urandom_range(0, 2 * cy > 16'hFFFF ? 16'hFFFF : 2 * cy)));
        end
        if (ph == 1 && n == 50) begin
          end_burst();
          while (pending != 0) @(posedge clk);
        end
      end
      end_burst();
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_camera_ray_direction_gen_top: PASS");
    end else begin
      $display("tb_camera_ray_direction_gen_top: FAIL");
    end
    $finish;
  end

endmodule
